// File: rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants of the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

    // Request codes; the unused code acts as a find
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_FIND   = 2'd2;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CFG_W       = 9;
    localparam int COUNT_W     = 11;
    localparam int REM_W       = 10;
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = KEY_W / DIV_BITS;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 48;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_DIV,
        ST_HRD,
        ST_HWT,
        ST_WALK,
        ST_DEC,
        ST_FRD,
        ST_NEW,
        ST_REP,
        ST_FREE,
        ST_LINK,
        ST_RESP
    } state_t;

endpackage

// File: rtl/chained_hash_table.sv
// ----------------------------------------------------------------------------
// chained_hash_table
// Key-value table with separate chaining over a fixed entry pool.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bucket head memory, one bucket per cycle,
// through all MAX_BUCKETS buckets before it takes the first request. A request
// then reduces the key modulo the bucket count (4 key bits per cycle), reads
// the bucket head, and walks the chain with one read of the entry memory per
// chain entry visited, followed by any write-back. The result sits in an
// output register, so the next request may enter while it waits.
module chained_hash_table #(
    parameter int MAX_BUCKETS  = 256,
    parameter int POOL_ENTRIES = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [cht_pkg::CFG_W-1:0]      cfg_wr_data,   // bucket_count
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cht_pkg::S_TDATA_W-1:0]  s_tdata,       // key, new_value
    input  logic [1:0]                     s_tuser,       // req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cht_pkg::M_TDATA_W-1:0]  m_tdata        // found, prior_value,
                                                          // status, entry_count, pad
);

    localparam int HW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int PW = $clog2(POOL_ENTRIES);
    localparam int LW = $clog2(POOL_ENTRIES + 1);
    localparam int EW = cht_pkg::KEY_W + cht_pkg::VAL_W + LW;
    localparam int KW = cht_pkg::KEY_W;
    localparam int VW = cht_pkg::VAL_W;
    localparam int RW = cht_pkg::REM_W;

    // Memories
    logic [LW-1:0] heads [MAX_BUCKETS];
    logic [EW-1:0] entries [POOL_ENTRIES];

    logic          hd_we;
    logic [HW-1:0] hd_waddr;
    logic [LW-1:0] hd_wdata;
    logic [HW-1:0] hd_raddr;
    logic [LW-1:0] hd_rdata_reg;
    logic          en_we;
    logic [PW-1:0] en_waddr;
    logic [EW-1:0] en_wdata;
    logic [PW-1:0] en_raddr;
    logic [EW-1:0] en_rdata_reg;

    cht_pkg::state_t state_reg, state_next;
    logic [cht_pkg::CFG_W-1:0] bucket_count_reg;
    logic [HW-1:0] clr_idx_reg, clr_idx_next;
    logic [1:0]    req_reg, req_next;
    logic [KW-1:0] key_reg, key_next;
    logic [VW-1:0] val_reg, val_next;
    logic [KW-1:0] dvd_reg, dvd_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] nb_reg, nb_next;
    logic [cht_pkg::STEP_W-1:0] step_reg, step_next;
    logic [HW-1:0] bkt_reg, bkt_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] prev_reg, prev_next;
    logic [KW-1:0] prev_key_reg, prev_key_next;
    logic [VW-1:0] prev_val_reg, prev_val_next;
    logic          hit_reg, hit_next;
    logic [VW-1:0] hit_val_reg, hit_val_next;
    logic [LW-1:0] nxt_link_reg, nxt_link_next;
    logic [PW-1:0] slot_reg, slot_next;
    logic [LW-1:0] link_reg, link_next;
    logic [LW-1:0] fresh_reg, fresh_next;
    logic [LW-1:0] fl_head_reg, fl_head_next;
    logic [LW-1:0] count_reg, count_next;
    logic          status_reg, status_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [cht_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [RW-1:0] n_eff;
    logic [RW-1:0] div_rem;
    logic [KW-1:0] div_dvd;
    logic [KW-1:0] rd_key;
    logic [VW-1:0] rd_val;
    logic [LW-1:0] rd_link;

    assign rd_key  = en_rdata_reg[KW-1:0];
    assign rd_val  = en_rdata_reg[KW+VW-1:KW];
    assign rd_link = en_rdata_reg[EW-1:KW+VW];

    // Clamp the configured bucket count into 1..MAX_BUCKETS
    always_comb begin
        if (bucket_count_reg == '0) begin
            n_eff = RW'(1);
        end else if (32'(bucket_count_reg) > 32'(MAX_BUCKETS)) begin
            n_eff = RW'(MAX_BUCKETS);
        end else begin
            n_eff = RW'(bucket_count_reg);
        end
    end

    // Restoring remainder, cht_pkg::DIV_BITS key bits per cycle
    always_comb begin
        div_rem = rem_reg;
        div_dvd = dvd_reg;
        for (int i = 0; i < cht_pkg::DIV_BITS; i++) begin
            div_rem = {div_rem[RW-2:0], div_dvd[KW-1]};
            div_dvd = {div_dvd[KW-2:0], 1'b0};
            if (div_rem >= nb_reg) begin
                div_rem = div_rem - nb_reg;
            end
        end
    end

    // Bucket head memory
    always_ff @(posedge aclk) begin
        if (hd_we) begin
            heads[hd_waddr] <= hd_wdata;
        end
        hd_rdata_reg <= heads[hd_raddr];
    end

    // Entry memory: {link, value, key}
    always_ff @(posedge aclk) begin
        if (en_we) begin
            entries[en_waddr] <= en_wdata;
        end
        en_rdata_reg <= entries[en_raddr];
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= cht_pkg::CFG_W'(256);
        end else if (cfg_wr_en) begin
            bucket_count_reg <= cfg_wr_data;
        end
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cht_pkg::ST_CLR;
            clr_idx_reg  <= '0;
            fresh_reg    <= '0;
            fl_head_reg  <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            fresh_reg    <= fresh_next;
            fl_head_reg  <= fl_head_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        nb_reg       <= nb_next;
        step_reg     <= step_next;
        bkt_reg      <= bkt_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        prev_key_reg <= prev_key_next;
        prev_val_reg <= prev_val_next;
        hit_reg      <= hit_next;
        hit_val_reg  <= hit_val_next;
        nxt_link_reg <= nxt_link_next;
        slot_reg     <= slot_next;
        link_reg     <= link_next;
        status_reg   <= status_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // Next state, memory accesses and result
    always_comb begin
        logic load;
        load          = 1'b0;
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        req_next      = req_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        nb_next       = nb_reg;
        step_next     = step_reg;
        bkt_next      = bkt_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        prev_key_next = prev_key_reg;
        prev_val_next = prev_val_reg;
        hit_next      = hit_reg;
        hit_val_next  = hit_val_reg;
        nxt_link_next = nxt_link_reg;
        slot_next     = slot_reg;
        link_next     = link_reg;
        fresh_next    = fresh_reg;
        fl_head_next  = fl_head_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        m_tdata_next  = m_tdata_reg;
        hd_we         = 1'b0;
        hd_waddr      = bkt_reg;
        hd_wdata      = link_reg;
        hd_raddr      = bkt_reg;
        en_we         = 1'b0;
        en_waddr      = slot_reg;
        en_wdata      = {LW'(0), val_reg, key_reg};
        en_raddr      = PW'(cur_reg - LW'(1));
        s_tready      = 1'b0;

        case (state_reg)
            // Sweep the bucket heads to empty
            cht_pkg::ST_CLR: begin
                hd_we    = 1'b1;
                hd_waddr = clr_idx_reg;
                hd_wdata = '0;
                clr_idx_next = clr_idx_reg + HW'(1);
                if (clr_idx_reg == HW'(MAX_BUCKETS - 1)) begin
                    state_next = cht_pkg::ST_IDLE;
                end
            end
            // Take a request
            cht_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    req_next    = s_tuser;
                    key_next    = s_tdata[KW-1:0];
                    val_next    = s_tdata[KW+VW-1:KW];
                    dvd_next    = s_tdata[KW-1:0];
                    rem_next    = '0;
                    nb_next     = n_eff;
                    step_next   = '0;
                    hit_next    = 1'b0;
                    status_next = 1'b0;
                    prev_next   = '0;
                    state_next  = cht_pkg::ST_DIV;
                end
            end
            // Reduce the key to a bucket
            cht_pkg::ST_DIV: begin
                rem_next  = div_rem;
                dvd_next  = div_dvd;
                step_next = step_reg + cht_pkg::STEP_W'(1);
                if (step_reg == cht_pkg::STEP_W'(cht_pkg::DIV_STEPS - 1)) begin
                    bkt_next   = HW'(div_rem);
                    state_next = cht_pkg::ST_HRD;
                end
            end
            cht_pkg::ST_HRD: begin
                state_next = cht_pkg::ST_HWT;
            end
            // Start the chain walk at the head
            cht_pkg::ST_HWT: begin
                cur_next = hd_rdata_reg;
                en_raddr = PW'(hd_rdata_reg - LW'(1));
                if (hd_rdata_reg == '0) begin
                    state_next = cht_pkg::ST_DEC;
                end else begin
                    state_next = cht_pkg::ST_WALK;
                end
            end
            // Compare one entry per cycle, advance on a miss
            cht_pkg::ST_WALK: begin
                if (rd_key == key_reg) begin
                    hit_next      = 1'b1;
                    hit_val_next  = rd_val;
                    nxt_link_next = rd_link;
                    state_next    = cht_pkg::ST_DEC;
                end else begin
                    prev_next     = cur_reg;
                    prev_key_next = rd_key;
                    prev_val_next = rd_val;
                    cur_next      = rd_link;
                    en_raddr      = PW'(rd_link - LW'(1));
                    if (rd_link == '0) begin
                        state_next = cht_pkg::ST_DEC;
                    end
                end
            end
            // Pick the update
            cht_pkg::ST_DEC: begin
                state_next = cht_pkg::ST_RESP;
                en_raddr   = PW'(fl_head_reg - LW'(1));
                case (req_reg)
                    cht_pkg::REQ_INSERT: begin
                        if (hit_reg) begin
                            state_next = cht_pkg::ST_REP;
                        end else if (count_reg >= LW'(POOL_ENTRIES)) begin
                            status_next = 1'b1;
                        end else if (fresh_reg < LW'(POOL_ENTRIES)) begin
                            slot_next  = PW'(fresh_reg);
                            fresh_next = fresh_reg + LW'(1);
                            state_next = cht_pkg::ST_NEW;
                        end else begin
                            state_next = cht_pkg::ST_FRD;
                        end
                    end
                    cht_pkg::REQ_REMOVE: begin
                        if (hit_reg) begin
                            state_next = cht_pkg::ST_FREE;
                        end
                    end
                    default: begin
                        state_next = cht_pkg::ST_RESP;
                    end
                endcase
            end
            // Pop the free list
            cht_pkg::ST_FRD: begin
                slot_next    = PW'(fl_head_reg - LW'(1));
                fl_head_next = rd_link;
                state_next   = cht_pkg::ST_NEW;
            end
            // Write the new tail entry
            cht_pkg::ST_NEW: begin
                en_we      = 1'b1;
                en_waddr   = slot_reg;
                en_wdata   = {LW'(0), val_reg, key_reg};
                link_next  = LW'(slot_reg) + LW'(1);
                count_next = count_reg + LW'(1);
                state_next = cht_pkg::ST_LINK;
            end
            // Replace the value in place
            cht_pkg::ST_REP: begin
                en_we      = 1'b1;
                en_waddr   = PW'(cur_reg - LW'(1));
                en_wdata   = {nxt_link_reg, val_reg, key_reg};
                state_next = cht_pkg::ST_RESP;
            end
            // Push the removed entry on the free list
            cht_pkg::ST_FREE: begin
                en_we        = 1'b1;
                en_waddr     = PW'(cur_reg - LW'(1));
                en_wdata     = {fl_head_reg, hit_val_reg, key_reg};
                fl_head_next = cur_reg;
                link_next    = nxt_link_reg;
                count_next   = count_reg - LW'(1);
                state_next   = cht_pkg::ST_LINK;
            end
            // Relink the predecessor or the bucket head
            cht_pkg::ST_LINK: begin
                if (prev_reg == '0) begin
                    hd_we = 1'b1;
                end else begin
                    en_we    = 1'b1;
                    en_waddr = PW'(prev_reg - LW'(1));
                    en_wdata = {link_reg, prev_val_reg, prev_key_reg};
                end
                state_next = cht_pkg::ST_RESP;
            end
            // Hand the result to the output register
            cht_pkg::ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    load         = 1'b1;
                    m_tdata_next = {3'b000, cht_pkg::COUNT_W'(count_reg), status_reg,
                                    (hit_reg ? hit_val_reg : VW'(0)), hit_reg};
                    state_next   = cht_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cht_pkg::ST_IDLE;
            end
        endcase

        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/cht_checker.sv
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks of the chained hash table, bound to the top level.
// ----------------------------------------------------------------------------
module cht_checker #(
    parameter int POOL_ENTRIES = 1024
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cht_pkg::M_TDATA_W-1:0]  m_tdata
);

    // A held result keeps its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request at a time: busy right after an accepted transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // The entry count never exceeds the pool
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[44:34]) <= 32'(POOL_ENTRIES))
        else $error("entry count above pool size");

    // A refused insert reports no hit and no value
    a_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33] |-> !m_tdata[0] && m_tdata[32:1] == 32'd0)
        else $error("refused insert reports a hit");

endmodule

bind chained_hash_table cht_checker #(.POOL_ENTRIES(POOL_ENTRIES)) u_cht_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
